>>> rtl/core/gpbs_pkg.sv
// shared types, constants and the log table builder for the gamma pixel search
`timescale 1ns / 1ps
`default_nettype none

package gpbs_pkg;

    localparam int PIXEL_W      = 8;
    localparam int GAMMA_W      = 16;
    localparam int GAMMA_FRAC   = 12;
    localparam int LOG_INT_BITS = 3;   // |ln(1/255)| < 8
    localparam int ACC_FRAC     = 60;
    localparam int TAB_W        = 64;
    localparam int TAB_DEPTH    = 256;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;

    // control that travels with each beat through the pipe
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

    typedef logic [TAB_DEPTH-1:0][TAB_W-1:0] t_ln_tab;

    // shift and subtract division, elaboration time only
    function automatic logic [TAB_W-1:0] udiv64(input logic [TAB_W-1:0] num,
                                                 input logic [TAB_W-1:0] den);
        logic [TAB_W:0]   rem;
        logic [TAB_W-1:0] quo;
        rem = '0;
        quo = '0;
        for (int i = TAB_W - 1; i >= 0; i--) begin
            rem = {rem[TAB_W-1:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln((q+1)/(q-1)) = 2*atanh(1/q), 60 fraction bits
    function automatic logic [TAB_W-1:0] ln_ratio(input logic [TAB_W-1:0] q);
        logic [TAB_W-1:0] p;
        logic [TAB_W-1:0] sum;
        logic [TAB_W-1:0] k;
        p   = udiv64(TAB_W'(1) << ACC_FRAC, q);
        sum = '0;
        k   = TAB_W'(1);
        for (int t = 0; t < TAB_W; t++) begin
            if (p != '0) begin
                sum = sum + udiv64(p, k);
                p   = udiv64(p, q * q);
                k   = k + TAB_W'(2);
            end
        end
        return sum << 1;
    endfunction

    // |ln(m/255)| rounded to frac bits, ties away from zero; entry 0 unused
    function automatic t_ln_tab build_ln_tab(input int frac);
        logic [TAB_W-1:0] lnm [TAB_DEPTH];
        logic [TAB_W-1:0] half;
        t_ln_tab          tab;
        half   = TAB_W'(1) << (ACC_FRAC - frac - 1);
        lnm[0] = '0;
        lnm[1] = '0;
        for (int m = 2; m < TAB_DEPTH; m++) begin
            lnm[m] = lnm[m-1] + ln_ratio(TAB_W'(2 * m - 1));
        end
        tab[0] = '0;
        for (int m = 1; m < TAB_DEPTH; m++) begin
            tab[m] = (lnm[TAB_DEPTH-1] - lnm[m] + half) >> (ACC_FRAC - frac);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/gpbs_search_stage.sv
// one step of the binary search: decides a single result bit against the log table
`timescale 1ns / 1ps
`default_nettype none

module gpbs_search_stage
    import gpbs_pkg::*;
#(
    parameter int LOG_FRAC_BITS = 16,
    parameter int BIT_POS       = 7
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire t_ctl                                   i_ctl,
    input  wire logic [LOG_FRAC_BITS+LOG_INT_BITS+GAMMA_W-GAMMA_FRAC-1:0] i_target,
    input  wire logic [PIXEL_W-1:0]                     i_m,
    output t_ctl                                        o_ctl,
    output logic [LOG_FRAC_BITS+LOG_INT_BITS+GAMMA_W-GAMMA_FRAC-1:0]      o_target,
    output logic [PIXEL_W-1:0]                          o_m
);

    localparam int      ROM_W  = LOG_FRAC_BITS + LOG_INT_BITS;
    localparam int      TGT_W  = ROM_W + GAMMA_W - GAMMA_FRAC;
    localparam t_ln_tab LN_TAB = build_ln_tab(LOG_FRAC_BITS);
    localparam logic [PIXEL_W-1:0] BIT_MASK = PIXEL_W'(1) << BIT_POS;

    t_ctl                 r_ctl;
    logic [TGT_W-1:0]     r_target;
    logic [PIXEL_W-1:0]   r_m;
    logic [PIXEL_W-1:0]   n_m;
    logic [PIXEL_W-1:0]   cand;
    logic [ROM_W-1:0]     cand_log;

    always_comb begin
        cand     = i_m | BIT_MASK;
        cand_log = LN_TAB[cand][ROM_W-1:0];
        // keep the bit when |ln(cand/255)| >= target, both compared as magnitudes
        if ({(TGT_W-ROM_W)'(0), cand_log} >= i_target) begin
            n_m = cand;
        end else begin
            n_m = i_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= i_target;
        r_m      <= n_m;
    end

    assign o_ctl    = r_ctl;
    assign o_target = r_target;
    assign o_m      = r_m;

endmodule

`default_nettype wire

>>> rtl/core/gamma_pixel_binary_search.sv
// top level: gamma correction of 8-bit pixels by log lookup, multiply and binary search
// Takes one pixel per clock whenever i_start is high and returns floor(255*(x/255)^gamma)
// on o_pixel_out, marked by a one-cycle o_done strobe, after the pixel has passed through
// a register each for the log table lookup, the gamma multiply and the rounding, and
// eight for the binary search, one result bit per stage. o_busy is always low and results
// come out in order at the input rate; the receiver must take each one as it appears.
// Gamma is unsigned Q4.12, reset to 1.0; change it only with no pixels in flight.
`timescale 1ns / 1ps
`default_nettype none

module gamma_pixel_binary_search
    import gpbs_pkg::*;
#(
    parameter int LOG_FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [PIXEL_W-1:0] i_pixel_in,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [GAMMA_W-1:0] i_cfg_wr_data,
    output logic                    o_done,
    output logic [PIXEL_W-1:0]      o_pixel_out
);

    localparam int      ROM_W   = LOG_FRAC_BITS + LOG_INT_BITS;
    localparam int      PROD_W  = ROM_W + GAMMA_W;
    localparam int      TGT_W   = PROD_W - GAMMA_FRAC;
    localparam int      NSTAGE  = PIXEL_W;
    localparam t_ln_tab LN_TAB  = build_ln_tab(LOG_FRAC_BITS);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAMMA_FRAC - 1);

    logic [GAMMA_W-1:0] r_gamma;

    t_ctl               r_s1_ctl;
    logic [ROM_W-1:0]   r_s1_log;
    t_ctl               r_s2_ctl;
    logic [PROD_W-1:0]  r_s2_prod;
    t_ctl               r_s3_ctl;
    logic [TGT_W-1:0]   r_s3_target;

    t_ctl               stg_ctl    [NSTAGE+1];
    logic [TGT_W-1:0]   stg_target [NSTAGE+1];
    logic [PIXEL_W-1:0] stg_m      [NSTAGE+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (i_cfg_wr_en) begin
            r_gamma <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else begin
            r_s1_ctl.valid <= i_start;
            r_s1_ctl.zero  <= (i_pixel_in == '0);
            r_s2_ctl       <= r_s1_ctl;
            r_s3_ctl       <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_log    <= LN_TAB[i_pixel_in][ROM_W-1:0];
        r_s2_prod   <= PROD_W'(r_gamma) * PROD_W'(r_s1_log);
        // round the product back to the table format
        r_s3_target <= TGT_W'((r_s2_prod + ROUND_HALF) >> GAMMA_FRAC);
    end

    assign stg_ctl[0]    = r_s3_ctl;
    assign stg_target[0] = r_s3_target;
    assign stg_m[0]      = '0;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_search
        gpbs_search_stage #(
            .LOG_FRAC_BITS (LOG_FRAC_BITS),
            .BIT_POS       (NSTAGE - 1 - g)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (stg_ctl[g]),
            .i_target (stg_target[g]),
            .i_m      (stg_m[g]),
            .o_ctl    (stg_ctl[g+1]),
            .o_target (stg_target[g+1]),
            .o_m      (stg_m[g+1])
        );
    end

    assign o_busy      = 1'b0;
    assign o_done      = stg_ctl[NSTAGE].valid;
    // a black pixel stays black whatever gamma is
    assign o_pixel_out = stg_ctl[NSTAGE].zero ? '0 : stg_m[NSTAGE];

endmodule

`default_nettype wire

>>> bench/gamma_pixel_binary_search_test.sv
// self-checking bench for the gamma pixel search: directed and random pixels over several gammas
`timescale 1ns / 1ps

module gamma_pixel_binary_search_test;
    import gpbs_pkg::*;

    localparam int LOG_FRAC      = 16;
    localparam int SERIES_FRAC   = 60;
    localparam int PIXELS_PER_GAMMA = 204;
    localparam int GAMMA_PHASES  = 8;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_start       = 1'b0;
    logic [PIXEL_W-1:0]   i_pixel_in    = '0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [GAMMA_W-1:0]   i_cfg_wr_data = '0;
    logic                 o_busy;
    logic                 o_done;
    logic [PIXEL_W-1:0]   o_pixel_out;

    longint unsigned      log_mag [256];
    logic [GAMMA_W-1:0]   gamma_now = GAMMA_RESET;
    logic [PIXEL_W-1:0]   corrected_due [$];
    int                   mismatches = 0;
    bit                   gaps_on = 1'b1;

    gamma_pixel_binary_search #(
        .LOG_FRAC_BITS(LOG_FRAC)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_pixel_in   (i_pixel_in),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_done       (o_done),
        .o_pixel_out  (o_pixel_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ln((q+1)/(q-1)) as 2*atanh(1/q), 60 fraction bits
    function automatic longint unsigned log_ratio_q60(longint unsigned q);
        longint unsigned p;
        longint unsigned acc;
        longint unsigned k;
        p   = (64'd1 << SERIES_FRAC) / q;
        acc = 0;
        k   = 1;
        while (p != 0) begin
            acc += p / k;
            p = p / (q * q);
            k += 2;
        end
        return acc * 2;
    endfunction

    // magnitude of ln(m/255) rounded to LOG_FRAC bits, ties away from zero
    function automatic void fill_log_table();
        longint unsigned ln_cum [256];
        longint unsigned half;
        half      = 64'd1 << (SERIES_FRAC - LOG_FRAC - 1);
        ln_cum[0] = 0;
        ln_cum[1] = 0;
        for (int m = 2; m < 256; m++) begin
            ln_cum[m] = ln_cum[m-1] + log_ratio_q60(64'(2 * m - 1));
        end
        log_mag[0] = 0;
        for (int m = 1; m < 256; m++) begin
            log_mag[m] = (ln_cum[255] - ln_cum[m] + half) >> (SERIES_FRAC - LOG_FRAC);
        end
    endfunction

    function automatic logic [PIXEL_W-1:0] corrected_pixel(logic [PIXEL_W-1:0] x,
                                                           logic [GAMMA_W-1:0] g);
        longint unsigned    bound;
        logic [PIXEL_W-1:0] m;
        logic [PIXEL_W-1:0] cand;
        if (x == '0) begin
            return '0;
        end
        bound = (64'(g) * log_mag[x] + 64'd2048) >> GAMMA_FRAC;
        m = '0;
        // one result bit per step, msb first
        for (int b = PIXEL_W - 1; b >= 0; b--) begin
            cand = m | (PIXEL_W'(1) << b);
            if (log_mag[cand] >= bound) begin
                m = cand;
            end
        end
        return m;
    endfunction

    task automatic send_pixel(logic [PIXEL_W-1:0] x);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_start    <= 1'b0;
            i_pixel_in <= PIXEL_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_pixel_in <= x;
        do @(posedge i_clk); while (o_busy);
        corrected_due.push_back(corrected_pixel(x, gamma_now));
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (corrected_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_gamma(logic [GAMMA_W-1:0] g);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= g;
        @(posedge i_clk);
        gamma_now = g;
        // data moves with the enable low and must not be taken
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= GAMMA_W'($urandom);
        @(posedge i_clk);
    endtask

    task automatic test_reset_gamma();
        logic [PIXEL_W-1:0] px [$] = '{8'd0, 8'd1, 8'd2, 8'h55, 8'hAA, 8'd127, 8'd128,
                                       8'd254, 8'd255};
        foreach (px[i]) send_pixel(px[i]);
    endtask

    task automatic test_gamma_extremes();
        logic [PIXEL_W-1:0] px_zero [$] = '{8'd0, 8'd1, 8'd128, 8'd255};
        logic [PIXEL_W-1:0] px_big  [$] = '{8'd0, 8'd1, 8'd200, 8'd254, 8'd255};
        logic [PIXEL_W-1:0] px_tiny [$] = '{8'd1, 8'd254};
        // zero gamma lifts every nonzero pixel to full scale
        set_gamma('0);
        foreach (px_zero[i]) send_pixel(px_zero[i]);
        // largest gamma saturates toward black
        set_gamma('1);
        foreach (px_big[i]) send_pixel(px_big[i]);
        set_gamma(GAMMA_W'(1));
        foreach (px_tiny[i]) send_pixel(px_tiny[i]);
    endtask

    task automatic test_random_gammas();
        logic [GAMMA_W-1:0] g;
        logic [PIXEL_W-1:0] x;
        int                 pick;
        for (int phase = 0; phase < GAMMA_PHASES; phase++) begin
            case (phase % 4)
                0: g = GAMMA_W'($urandom_range(0, 65535));
                1: g = GAMMA_W'($urandom_range(1024, 16384));
                2: g = GAMMA_W'($urandom_range(0, 63));
                default: g = GAMMA_W'($urandom_range(3900, 4300));
            endcase
            set_gamma(g);
            for (int n = 0; n < PIXELS_PER_GAMMA; n++) begin
                // stretches of back-to-back beats between gappy ones
                if (n % 40 == 0) begin
                    gaps_on = ($urandom_range(0, 2) != 0);
                end
                pick = $urandom_range(0, 15);
                case (pick)
                    0: x = '0;
                    1: x = '1;
                    2: x = PIXEL_W'($urandom_range(1, 3));
                    default: x = PIXEL_W'($urandom_range(0, 255));
                endcase
                send_pixel(x);
            end
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (corrected_due.size() == 0) begin
                $error("pixel_out: expected none, actual %0d", o_pixel_out);
                mismatches++;
            end else begin
                if (o_pixel_out !== corrected_due[0]) begin
                    $error("pixel_out: expected %0d, actual %0d", corrected_due[0],
                           o_pixel_out);
                    mismatches++;
                end
                void'(corrected_due.pop_front());
            end
        end
    end

    initial begin
        fill_log_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_gamma();
        test_gamma_extremes();
        test_random_gammas();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && corrected_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/gpbs_pkg.sv
rtl/core/gpbs_search_stage.sv
rtl/core/gamma_pixel_binary_search.sv
bench/gamma_pixel_binary_search_test.sv
